@@ hdl/frame_free_list_allocator_top_defines.svh @@
// assertion macros for the frame free-list allocator
// used by frame_free_list_allocator_top, no other dependencies
`ifndef FRAME_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define FRAME_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// condition that must hold at every edge outside reset
`define FFLA_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define FFLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ffla_pkg.sv @@
// shared types and constants for the frame free-list allocator
// no dependencies; used by the interfaces, the output stage and the top level
package ffla_pkg;

    // field widths fixed by the request and response formats
    localparam int FRAME_W       = 8;
    localparam int FRAME_COUNT_W = 9;
    localparam int STATUS_W      = 2;

    // parameter defaults
    localparam int MAX_FRAMES_DEF = 256;
    localparam int NODE_LIMIT_DEF = 512;

    // frame count after reset
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 9'd256;

    // request function codes
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_UNTRACKED = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // one response item
    typedef struct packed {
        t_status              status;
        logic [FRAME_W-1:0]   frame_out;
    } t_rsp;

endpackage

@@ hdl/ffla_if.sv @@
// valid/ready channel interfaces: request, response and configuration
// depends on ffla_pkg

// request channel: allocate or release
interface ffla_req_if import ffla_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [FRAME_W-1:0] frame_in;

    modport source (output valid, func, frame_in, input ready);
    modport sink   (input valid, func, frame_in, output ready);
endinterface

// response channel: status and handed-out frame
interface ffla_rsp_if import ffla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_out;

    modport source (output valid, status, frame_out, input ready);
    modport sink   (input valid, status, frame_out, output ready);
endinterface

// configuration channel: frame count register write
interface ffla_cfg_if import ffla_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FRAME_COUNT_W-1:0] frame_count;

    modport source (output valid, frame_count, input ready);
    modport sink   (input valid, frame_count, output ready);
endinterface

@@ hdl/ffla_out_stage.sv @@
// response output register: holds one result until the sink takes it
// depends on ffla_pkg and ffla_rsp_if
module ffla_out_stage import ffla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_rsp              i_rsp,
    output logic              o_stall,
    ffla_rsp_if.source        o_rsp
);

    logic r_valid;
    logic n_valid;
    t_rsp r_data;

    // a held result blocks a new load until taken
    assign o_stall = r_valid && !o_rsp.ready;

    always_comb begin
        n_valid = r_valid && !o_rsp.ready;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    // valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_rsp;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.status    = r_data.status;
    assign o_rsp.frame_out = r_data.frame_out;

endmodule

@@ hdl/frame_free_list_allocator_top.sv @@
// frame free-list allocator: lifo free stack and per-frame used counts in memories
// depends on ffla_pkg, ffla_if, ffla_out_stage and the assertion macro header
//
//  channel   dir   modport  transaction
//  i_req     in    sink     func + frame_in (allocate or release)
//  o_rsp     out   source   status + frame_out
//  i_cfg     in    sink     frame_count write, rebuilds the pool
//
// a release passes through S_UPD, an allocate through S_POP and then S_UPD: each waits on the
// registered read of the count memory, and an allocate first on the read of the stack memory
// a new request is taken once the previous one has written its result
// after reset and after each frame_count write, a clearing pass over all min(MAX_FRAMES, 512)
// entries of the count memory runs with no request taken
// a result that the sink does not take holds the update stage until it drains
`include "frame_free_list_allocator_top_defines.svh"

module frame_free_list_allocator_top import ffla_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int NODE_LIMIT = NODE_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffla_req_if.sink    i_req,
    ffla_rsp_if.source  o_rsp,
    ffla_cfg_if.sink    i_cfg
);

    // counts of entries and nodes reach NODE_LIMIT itself
    localparam int CNT_W    = $clog2(NODE_LIMIT + 1);
    localparam int SA_W     = $clog2(NODE_LIMIT);
    localparam int KEY_W    = FRAME_COUNT_W;
    localparam int KEY_SPAN = 2 ** FRAME_COUNT_W;
    localparam int UC_DEPTH = (MAX_FRAMES < KEY_SPAN) ? MAX_FRAMES : KEY_SPAN;
    localparam int UC_AW    = $clog2(UC_DEPTH);
    localparam int CLAMP    = (MAX_FRAMES < NODE_LIMIT) ? MAX_FRAMES : NODE_LIMIT;
    localparam int RST_POOL = (int'(FRAME_COUNT_RST) > CLAMP) ? CLAMP : int'(FRAME_COUNT_RST);

    localparam logic [CNT_W-1:0] LIMIT_C    = CNT_W'(NODE_LIMIT);
    localparam logic [CNT_W-1:0] RST_POOL_C = CNT_W'(RST_POOL);
    localparam logic [UC_AW-1:0] CLR_LAST   = UC_AW'(UC_DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_POP   = 4'b0100,
        S_UPD   = 4'b1000
    } t_state;

    // control and pool registers
    t_state                   r_state, n_state;
    logic [UC_AW-1:0]         r_clr, n_clr;
    logic [FRAME_COUNT_W-1:0] r_frame_count, n_frame_count;
    logic [CNT_W-1:0]         r_top, n_top;
    logic [CNT_W-1:0]         r_nodes, n_nodes;
    logic [CNT_W-1:0]         r_base, n_base;
    logic [CNT_W-1:0]         r_minw, n_minw;
    logic                     r_func, n_func;
    logic [KEY_W-1:0]         r_key, n_key;

    // memories and their registered read data
    logic [CNT_W-1:0] uc_mem  [UC_DEPTH];
    logic [KEY_W-1:0] stk_mem [NODE_LIMIT];
    logic [CNT_W-1:0] r_ud;
    logic [KEY_W-1:0] r_sd;

    logic             uc_we, uc_re;
    logic [UC_AW-1:0] uc_waddr, uc_raddr;
    logic [CNT_W-1:0] uc_wdata;
    logic             stk_we, stk_re;
    logic [SA_W-1:0]  stk_raddr;

    logic [CNT_W-1:0] pop_idx;
    int               init_v;
    int               cfg_pool_v;
    logic [KEY_W-1:0] init_val;
    logic [KEY_W-1:0] popped;
    logic [KEY_W-1:0] rel_key;
    logic [CNT_W-1:0] cfg_pool;
    logic             popped_ok, rel_ok, key_ok;
    logic             tracked, do_push;
    logic             req_acc, cfg_acc;
    logic             rsp_load, out_stall;
    t_rsp             rsp;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    // pool size after clamping the written count
    assign cfg_pool_v = (int'(i_cfg.frame_count) > CLAMP) ? CLAMP : int'(i_cfg.frame_count);
    assign cfg_pool   = CNT_W'(cfg_pool_v);

    // top entry; entries below the lowest written index still hold the initial frames
    assign pop_idx   = r_top - CNT_W'(1);
    assign stk_raddr = pop_idx[SA_W-1:0];
    assign init_v    = int'(r_base) - int'(pop_idx) - 1;
    assign init_val  = KEY_W'(init_v);
    assign popped    = (pop_idx < r_minw) ? init_val : r_sd;

    // frames that have a used count
    assign rel_key   = KEY_W'(i_req.frame_in);
    assign popped_ok = int'(popped) < MAX_FRAMES;
    assign rel_ok    = int'(rel_key) < MAX_FRAMES;
    assign key_ok    = int'(r_key) < MAX_FRAMES;
    assign tracked   = key_ok && (r_ud != '0);

    // sequencer: read, decide, write back
    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_frame_count = r_frame_count;
        n_top         = r_top;
        n_nodes       = r_nodes;
        n_base        = r_base;
        n_minw        = r_minw;
        n_func        = r_func;
        n_key         = r_key;
        uc_we         = 1'b0;
        uc_waddr      = r_key[UC_AW-1:0];
        uc_wdata      = '0;
        uc_re         = 1'b0;
        uc_raddr      = rel_key[UC_AW-1:0];
        stk_we        = 1'b0;
        stk_re        = 1'b0;
        rsp_load      = 1'b0;
        rsp.status    = ST_OK;
        rsp.frame_out = '0;
        do_push       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                uc_we    = 1'b1;
                uc_waddr = r_clr;
                n_clr    = r_clr + UC_AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_func = i_req.func;
                    if (i_req.func == FUNC_ALLOC) begin
                        stk_re  = 1'b1;
                        n_state = S_POP;
                    end else begin
                        n_key    = rel_key;
                        uc_re    = rel_ok;
                        uc_raddr = rel_key[UC_AW-1:0];
                        n_state  = S_UPD;
                    end
                end
            end
            S_POP: begin
                // fetch the used count of the frame about to be handed out
                n_key    = popped;
                uc_re    = popped_ok && (r_top != '0);
                uc_raddr = popped[UC_AW-1:0];
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (!out_stall) begin
                    rsp_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_func == FUNC_ALLOC) begin
                        if (r_top == '0) begin
                            rsp.status = ST_EMPTY;
                        end else begin
                            n_top         = pop_idx;
                            rsp.frame_out = r_key[FRAME_W-1:0];
                            if (key_ok) begin
                                uc_we    = 1'b1;
                                uc_wdata = r_ud + CNT_W'(1);
                            end
                        end
                    end else if (tracked) begin
                        uc_we    = 1'b1;
                        uc_wdata = r_ud - CNT_W'(1);
                        do_push  = 1'b1;
                    end else if (r_nodes >= LIMIT_C) begin
                        rsp.status = ST_FULL;
                    end else begin
                        n_nodes    = r_nodes + CNT_W'(1);
                        do_push    = 1'b1;
                        rsp.status = ST_UNTRACKED;
                    end
                    // push the released frame and track the lowest written entry
                    if (do_push && (r_top < LIMIT_C)) begin
                        stk_we = 1'b1;
                        n_top  = r_top + CNT_W'(1);
                        if (r_top < r_minw) begin
                            n_minw = r_top;
                        end
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase

        // register write rebuilds the pool
        if (cfg_acc) begin
            n_frame_count = i_cfg.frame_count;
            n_top         = cfg_pool;
            n_nodes       = cfg_pool;
            n_base        = cfg_pool;
            n_minw        = LIMIT_C;
            n_clr         = '0;
            n_state       = S_CLEAR;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_frame_count <= FRAME_COUNT_RST;
            r_top         <= RST_POOL_C;
            r_nodes       <= RST_POOL_C;
            r_base        <= RST_POOL_C;
            r_minw        <= LIMIT_C;
        end else begin
            r_state       <= n_state;
            r_clr         <= n_clr;
            r_frame_count <= n_frame_count;
            r_top         <= n_top;
            r_nodes       <= n_nodes;
            r_base        <= n_base;
            r_minw        <= n_minw;
        end
    end

    // request payload held through the sequence
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_key  <= n_key;
    end

    // used count memory
    always_ff @(posedge i_clk) begin
        if (uc_we) begin
            uc_mem[uc_waddr] <= uc_wdata;
        end
        if (uc_re) begin
            r_ud <= uc_mem[uc_raddr];
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[r_top[SA_W-1:0]] <= r_key;
        end
        if (stk_re) begin
            r_sd <= stk_mem[stk_raddr];
        end
    end

    // response register
    ffla_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (rsp_load),
        .i_rsp   (rsp),
        .o_stall (out_stall),
        .o_rsp   (o_rsp)
    );

    // checks
    `FFLA_ASSERT_ALWAYS(a_top_within_nodes, i_clk, i_rst_n, r_top <= r_nodes, "free stack deeper than node total")
    `FFLA_ASSERT_ALWAYS(a_nodes_bounded, i_clk, i_rst_n, r_nodes <= LIMIT_C, "node total above limit")
    `FFLA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, req_acc, !i_req.ready, "request taken while one is in flight")
    `FFLA_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, rsp_load, o_rsp.valid, "update did not reach output")

endmodule

@@ tb/sv/tb_frame_free_list_allocator_top.sv @@
// self-checking testbench for frame_free_list_allocator_top: directed and random
// allocate/release traffic, checked against an in-bench model of the free stack
// depends on ffla_pkg, the ffla_if channel interfaces and the allocator rtl
module tb_frame_free_list_allocator_top;
    import ffla_pkg::*;

    localparam int MAX_FRAMES    = MAX_FRAMES_DEF;
    localparam int NODE_LIMIT    = NODE_LIMIT_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int CYCLE_LIMIT   = 400000;

    // one request transaction waiting to be driven
    typedef struct {
        logic               func;
        logic [FRAME_W-1:0] frame;
    } t_frame_req;

    logic i_clk;
    logic i_rst_n;

    ffla_req_if req_if();
    ffla_rsp_if rsp_if();
    ffla_cfg_if cfg_if();

    frame_free_list_allocator_top #(
        .MAX_FRAMES (MAX_FRAMES),
        .NODE_LIMIT (NODE_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // requests still to be driven, and outcomes still to be seen on the response side
    t_frame_req req_pending_q[$];
    t_rsp       alloc_outcome_q[$];
    t_frame_req next_req;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // shadow of the pool: free stack, per-frame use counts, node total
    logic [FRAME_COUNT_W-1:0] frame_count_reg;
    logic [FRAME_W-1:0]       free_stack [NODE_LIMIT];
    int unsigned              stack_depth;
    int unsigned              used_count [MAX_FRAMES];
    int unsigned              node_total;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // rebuild the shadow pool from the frame count, clamped to what the block holds
    function automatic void rebuild_pool();
        int unsigned n;
        n = frame_count_reg;
        if (n > MAX_FRAMES) n = MAX_FRAMES;
        if (n > NODE_LIMIT) n = NODE_LIMIT;
        for (int i = 0; i < NODE_LIMIT; i++) free_stack[i] = '0;
        for (int i = 0; i < MAX_FRAMES; i++) used_count[i] = 0;
        for (int i = 0; i < n; i++) free_stack[i] = FRAME_W'(n - 1 - i);
        stack_depth = n;
        node_total  = n;
    endfunction

    // push a frame onto the shadow stack, which cannot overflow by construction
    function automatic void push_free(logic [FRAME_W-1:0] frame);
        if (stack_depth < NODE_LIMIT) begin
            free_stack[stack_depth] = frame;
            stack_depth++;
        end
    endfunction

    // outcome of one request, updating the shadow pool
    function automatic t_rsp pool_outcome(t_frame_req r);
        t_rsp  res;
        logic  tracked;
        res.status    = ST_OK;
        res.frame_out = '0;
        if (r.func == FUNC_ALLOC) begin
            if (stack_depth == 0) begin
                res.status = ST_EMPTY;
            end else begin
                stack_depth--;
                res.frame_out = free_stack[stack_depth];
                if (res.frame_out < MAX_FRAMES) used_count[res.frame_out]++;
            end
        end else begin
            tracked = (r.frame < MAX_FRAMES) && (used_count[r.frame] != 0);
            if (tracked) begin
                used_count[r.frame]--;
                push_free(r.frame);
            end else if (node_total >= NODE_LIMIT) begin
                res.status = ST_FULL;
            end else begin
                node_total++;
                push_free(r.frame);
                res.status = ST_UNTRACKED;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0d] mismatch on %s: got %0d, want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // request driver: next transaction from the pending queue, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = req_pending_q.pop_front();
                req_if.valid    <= 1'b1;
                req_if.func     <= next_req.func;
                req_if.frame_in <= next_req.frame;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // accepted request: work out the outcome it must give
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            alloc_outcome_q.push_back(pool_outcome('{req_if.func, req_if.frame_in}));
        end
    end

    // accepted response: compare against the oldest outcome
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (alloc_outcome_q.size() == 0) begin
                // response with no request outstanding
                report_mismatch("outstanding requests", 0, 1);
            end else begin
                t_rsp want;
                want = alloc_outcome_q.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.frame_out !== want.frame_out)
                    report_mismatch("frame_out", rsp_if.frame_out, want.frame_out);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_req(logic func, int frame);
        req_pending_q.push_back('{func, FRAME_W'(frame)});
    endtask

    // wait until every request has been answered, then let the pipeline empty
    task automatic wait_drained();
        while (req_pending_q.size() != 0 || req_if.valid || alloc_outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // frame count write, only while the block is idle
    task automatic write_frame_count(logic [FRAME_COUNT_W-1:0] value);
        cfg_if.valid       <= 1'b1;
        cfg_if.frame_count <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        frame_count_reg = value;
        rebuild_pool();
    endtask

    // mixed traffic: releases mostly hit a low window where frames are handed out
    task automatic add_mixed(int n, int hot);
        logic func;
        int   frame;
        for (int i = 0; i < n; i++) begin
            func = ($urandom_range(99) < 50) ? FUNC_ALLOC : FUNC_RELEASE;
            if (func == FUNC_RELEASE && $urandom_range(99) < 75)
                frame = $urandom_range(hot, 0);
            else
                frame = $urandom_range(255, 0);
            add_req(func, frame);
        end
    endtask

    // main sequence
    initial begin
        int small_count;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.func        = FUNC_ALLOC;
        req_if.frame_in    = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.frame_count = '0;
        send_idle_pct      = 17;
        recv_idle_pct      = 53;
        mismatch_count     = 0;
        cycle_count        = 0;
        frame_count_reg    = FRAME_COUNT_RST;
        rebuild_pool();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool: pops in order, tracked and untracked returns
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_ALLOC, 255);
        add_req(FUNC_RELEASE, 0);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_RELEASE, 255);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_RELEASE, 255);
        add_req(FUNC_RELEASE, 1);
        wait_drained();

        // empty pool: empty status, untracked frame becomes allocatable
        write_frame_count(FRAME_COUNT_W'(0));
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_RELEASE, 0);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_RELEASE, 0);
        wait_drained();

        // oversized count, clamped on rebuild
        write_frame_count(9'h1FF);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_RELEASE, 8'hAA);
        add_req(FUNC_RELEASE, 8'h55);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_ALLOC, 0);
        add_req(FUNC_RELEASE, 8'h55);
        wait_drained();

        // small pool: frame beyond the count, then run dry
        write_frame_count(FRAME_COUNT_W'(3));
        add_req(FUNC_RELEASE, 200);
        repeat (5) add_req(FUNC_ALLOC, 0);
        wait_drained();

        // full pool, sender pauses half way until every response is in
        write_frame_count(FRAME_COUNT_RST);
        add_mixed(150, 31);
        wait_drained();
        add_mixed(150, 31);
        wait_drained();

        // small random pool, idling swapped
        send_idle_pct = 53;
        recv_idle_pct = 17;
        small_count   = $urandom_range(24, 1);
        write_frame_count(FRAME_COUNT_W'(small_count));
        add_mixed(350, small_count - 1);
        wait_drained();

        // no idling: untracked flood up to the node limit, then mixed traffic
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_frame_count(FRAME_COUNT_RST);
        repeat (280) add_req(FUNC_RELEASE, $urandom_range(255, 0));
        add_mixed(150, 31);
        wait_drained();
        write_frame_count(FRAME_COUNT_W'($urandom_range(510, 257)));
        add_mixed(150, 31);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && alloc_outcome_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
